// ----- rtl/rqu_pkg.sv -----
// rqu_pkg: shared types, constants and single precision helper functions
// for the int32 to int8 requantizer; no dependencies
package rqu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int FMUL_LAT    = 3;
    localparam int FADD_LAT    = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVATION_KIND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAKY_SLOPE     = 2'd1;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_SIX  = 32'h40C0_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELU  = 2'd1,
        ACT_LEAKY = 2'd2,
        ACT_CLAMP = 2'd3
    } act_kind_t;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
    } fp_class_t;

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    // right shift keeping a sticky bit in the lsb
    function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [9:0] k);
        logic [26:0] mask;
        if (k >= 10'd27)
        begin
            return {26'd0, |m};
        end
        mask = (27'd1 << k[4:0]) - 27'd1;
        return (m >> k[4:0]) | {26'd0, |(m & mask)};
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // sig has its leading one at bit 26, three extra bits below the fraction
    function automatic logic [31:0] round_pack(input logic s, input logic signed [9:0] e,
                                               input logic [26:0] sig);
        logic [26:0] m;
        logic [7:0] ef;
        logic [9:0] k;
        logic up;
        if (e >= 10'sd255)
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (e <= 10'sd0)
        begin
            k = 10'sd1 - e;
            m = shr_sticky(sig, k);
            ef = 8'd0;
        end
        else
        begin
            m = sig;
            ef = e[7:0];
        end
        up = m[2] & (m[1] | m[0] | m[3]);
        return {s, ef, m[25:3]} + {31'd0, up};
    endfunction

endpackage

// ----- rtl/rqu_fmul.sv -----
// rqu_fmul: three stage single precision multiplier, round to nearest even
// depends on rqu_pkg
module rqu_fmul
    import rqu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] y
);

    logic        va_reg, vb_reg, vc_reg;
    logic        sa_reg, sb_reg;
    fp_class_t   ca_reg, cb_reg;
    logic [8:0]  esum_reg;
    logic [47:0] prod_reg;
    logic signed [9:0] eb_reg;
    logic [26:0] sig_reg;
    logic [31:0] y_reg;

    fp_class_t   ca_next;
    logic [8:0]  esum_next;
    logic [47:0] prod_next;
    logic [5:0]  lz;
    logic [47:0] pn;
    logic signed [9:0] eb_next;
    logic [26:0] sig_next;
    logic [31:0] y_next;

    always_comb
    begin
        ca_next.nan  = is_nan(a) | is_nan(b) | (is_inf(a) & is_zero(b)) | (is_zero(a) & is_inf(b));
        ca_next.inf  = is_inf(a) | is_inf(b);
        ca_next.zero = is_zero(a) | is_zero(b);
        esum_next = 9'((a[30:23] == 8'd0) ? 8'd1 : a[30:23])
                  + 9'((b[30:23] == 8'd0) ? 8'd1 : b[30:23]);
        prod_next = {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
    end

    always_comb
    begin
        lz = lzc48(prod_reg);
        pn = prod_reg << lz;
        eb_next = $signed({1'b0, esum_reg}) - 10'sd126 - $signed({4'd0, lz});
        sig_next = {pn[47:22], |pn[21:0]};
    end

    always_comb
    begin
        if (cb_reg.nan)
            y_next = FP_QNAN;
        else if (cb_reg.inf)
            y_next = {sb_reg, 8'hFF, 23'd0};
        else if (cb_reg.zero)
            y_next = {sb_reg, 31'd0};
        else
            y_next = round_pack(sb_reg, eb_reg, sig_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg   <= a[31] ^ b[31];
            ca_reg   <= ca_next;
            esum_reg <= esum_next;
            prod_reg <= prod_next;
            sb_reg   <= sa_reg;
            cb_reg   <= ca_reg;
            eb_reg   <= eb_next;
            sig_reg  <= sig_next;
            y_reg    <= y_next;
        end
    end

    assign out_valid = vc_reg;
    assign y = y_reg;

endmodule

// ----- rtl/rqu_fadd.sv -----
// rqu_fadd: four stage single precision adder (align, add, normalize, round)
// depends on rqu_pkg
module rqu_fadd
    import rqu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] y
);

    logic [3:0]  v_reg;
    // per stage special flags, sign of an infinite operand and sign of the larger operand
    fp_class_t   c1_reg, c2_reg, c3_reg;
    logic        si1_reg, si2_reg, si3_reg;
    logic        sl1_reg, sl2_reg, sl3_reg;
    logic        sub1_reg, sub2_reg, sub3_reg;
    logic [7:0]  el1_reg, el2_reg;
    logic [26:0] ml_reg, ms_reg;
    logic [27:0] sum_reg;
    logic signed [9:0] e3_reg;
    logic [26:0] sig_reg;
    logic [31:0] y_reg;

    logic [31:0] big, sml;
    logic [7:0]  eL, eS;
    fp_class_t   c1_next;
    logic        si_next;
    logic [26:0] ms_next;
    logic [27:0] sum_next;
    logic [4:0]  lz;
    logic [27:0] sn;
    logic signed [9:0] e3_next;
    logic [26:0] sig_next;
    logic [31:0] y_next;

    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        eL = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eS = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        c1_next.nan  = is_nan(a) | is_nan(b) | (is_inf(a) & is_inf(b) & (a[31] ^ b[31]));
        c1_next.inf  = is_inf(a) | is_inf(b);
        c1_next.zero = 1'b0;
        si_next = is_inf(a) ? a[31] : b[31];
        ms_next = shr_sticky({(sml[30:23] != 8'd0), sml[22:0], 3'd0}, {2'd0, eL - eS});
    end

    always_comb
    begin
        if (sub1_reg)
            sum_next = {1'b0, ml_reg} - {1'b0, ms_reg};
        else
            sum_next = {1'b0, ml_reg} + {1'b0, ms_reg};
    end

    always_comb
    begin
        lz = lzc28(sum_reg);
        sn = sum_reg << lz;
        e3_next = $signed({2'd0, el2_reg}) + 10'sd1 - $signed({5'd0, lz});
        sig_next = {sn[27:2], |sn[1:0]};
    end

    always_comb
    begin
        if (c3_reg.nan)
            y_next = FP_QNAN;
        else if (c3_reg.inf)
            y_next = {si3_reg, 8'hFF, 23'd0};
        else if (c3_reg.zero)
            y_next = {(sub3_reg ? 1'b0 : sl3_reg), 31'd0};
        else
            y_next = round_pack(sl3_reg, e3_reg, sig_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c1_next;
            si1_reg  <= si_next;
            sl1_reg  <= big[31];
            sub1_reg <= a[31] ^ b[31];
            el1_reg  <= eL;
            ml_reg   <= {(big[30:23] != 8'd0), big[22:0], 3'd0};
            ms_reg   <= ms_next;

            c2_reg   <= c1_reg;
            si2_reg  <= si1_reg;
            sl2_reg  <= sl1_reg;
            sub2_reg <= sub1_reg;
            el2_reg  <= el1_reg;
            sum_reg  <= sum_next;

            c3_reg.nan  <= c2_reg.nan;
            c3_reg.inf  <= c2_reg.inf;
            c3_reg.zero <= sum_reg == 28'd0;
            si3_reg  <= si2_reg;
            sl3_reg  <= sl2_reg;
            sub3_reg <= sub2_reg;
            e3_reg   <= e3_next;
            sig_reg  <= sig_next;

            y_reg    <= y_next;
        end
    end

    assign out_valid = v_reg[3];
    assign y = y_reg;

endmodule

// ----- rtl/rqu_round.sv -----
// rqu_round: output stage, rounds a single precision value half away from zero
// and saturates to -127..127; depends on rqu_pkg
module rqu_round
    import rqu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       x,
    output logic              out_valid,
    output logic signed [7:0] q
);

    logic              v_reg;
    logic signed [7:0] q_reg;

    logic [7:0]  e;
    logic [23:0] m24;
    logic [23:0] t2;
    logic [8:0]  inc;
    logic [7:0]  mag;
    logic signed [7:0] q_next;

    always_comb
    begin
        e = x[30:23];
        m24 = {1'b1, x[22:0]};
        t2 = m24 >> 5'(8'd149 - e);
        inc = t2[8:0] + 9'd1;
        if (is_nan(x))
            mag = 8'd0;
        else if ((e > 8'd133) || ((e == 8'd133) && (m24 >= 24'hFF0000)))
            mag = 8'd127;
        else if (e < 8'd126)
            mag = 8'd0;
        else
            mag = inc[8:1];
        q_next = x[31] ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign out_valid = v_reg;
    assign q = q_reg;

endmodule

// ----- rtl/int32_to_int8_requantizer_unit.sv -----
// Requantizes a signed 32-bit accumulator to int8 through single precision
// scale, bias, activation and output scale, one transaction per clock.
// The stages run in order: int to float, multiply by dequant_scale, add bias,
// activation select, activation multiply, multiply by quant_scale and
// round/saturate. A new transaction is taken every cycle; the whole pipeline
// holds while a result waits with out_stall high. Depends on rqu_pkg, rqu_fmul,
// rqu_fadd and rqu_round.
module int32_to_int8_requantizer_unit
    import rqu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_write_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [31:0]     accumulator,
    input  logic [31:0]            dequant_scale,
    input  logic [31:0]            bias_value,
    input  logic [31:0]            quant_scale,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [7:0]      quantized
);

    localparam int SO_LAT = FMUL_LAT + FADD_LAT + 1 + FMUL_LAT;

    act_kind_t   activation_kind_reg;
    logic [31:0] leaky_slope_reg;

    logic        en;
    logic        s1_valid_reg;
    logic [31:0] s1_acc_reg, s1_si_reg, s1_bias_reg, s1_so_reg;
    logic [31:0] bias_line_reg [FMUL_LAT];
    logic [31:0] so_line_reg [SO_LAT];
    logic        act_valid_reg;
    logic [31:0] act_a_reg, act_b_reg;

    logic        neg;
    logic [31:0] mag;
    logic [5:0]  lz;
    logic [31:0] nrm;
    logic [31:0] acc_f_next;
    logic        m1_valid, ad_valid, m2_valid, m3_valid;
    logic [31:0] prod, v, act, y;
    logic        v_nan, v_gtz, v_ltz, v_gt6;
    logic [31:0] act_a_next, act_b_next;

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            activation_kind_reg <= ACT_NONE;
            leaky_slope_reg <= 32'd0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_ACTIVATION_KIND: activation_kind_reg <= act_kind_t'(cfg_write_data[1:0]);
                CFG_LEAKY_SLOPE:     leaky_slope_reg <= cfg_write_data;
                default: ;
            endcase
        end
    end

    // int to float
    always_comb
    begin
        neg = accumulator[31];
        mag = neg ? (32'd0 - accumulator) : accumulator;
        lz = lzc32(mag);
        nrm = mag << lz;
        if (mag == 32'd0)
            acc_f_next = 32'd0;
        else
            acc_f_next = round_pack(neg, 10'sd158 - $signed({4'd0, lz}),
                                    {nrm[31:6], |nrm[5:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            act_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            act_valid_reg <= ad_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_acc_reg  <= acc_f_next;
            s1_si_reg   <= dequant_scale;
            s1_bias_reg <= bias_value;
            s1_so_reg   <= quant_scale;
            bias_line_reg[0] <= s1_bias_reg;
            for (int i = 1; i < FMUL_LAT; i++)
                bias_line_reg[i] <= bias_line_reg[i-1];
            so_line_reg[0] <= s1_so_reg;
            for (int i = 1; i < SO_LAT; i++)
                so_line_reg[i] <= so_line_reg[i-1];
            act_a_reg <= act_a_next;
            act_b_reg <= act_b_next;
        end
    end

    rqu_fmul u_mul_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .a         (s1_acc_reg),
        .b         (s1_si_reg),
        .out_valid (m1_valid),
        .y         (prod)
    );

    rqu_fadd u_add_bias (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m1_valid),
        .a         (prod),
        .b         (bias_line_reg[FMUL_LAT-1]),
        .out_valid (ad_valid),
        .y         (v)
    );

    // activation select, leaky slope applied by the following multiplier
    always_comb
    begin
        v_nan = is_nan(v);
        v_gtz = !v[31] && !is_zero(v) && !v_nan;
        v_ltz = v[31] && !is_zero(v) && !v_nan;
        v_gt6 = !v[31] && !v_nan && (v[30:0] > FP_SIX[30:0]);
        act_a_next = v;
        act_b_next = FP_ONE;
        case (activation_kind_reg)
            ACT_RELU:  act_a_next = v_gtz ? v : 32'd0;
            ACT_LEAKY: act_b_next = v_gtz ? FP_ONE : leaky_slope_reg;
            ACT_CLAMP: act_a_next = v_ltz ? 32'd0 : (v_gt6 ? FP_SIX : v);
            default:   act_a_next = v;
        endcase
    end

    rqu_fmul u_mul_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (act_valid_reg),
        .a         (act_a_reg),
        .b         (act_b_reg),
        .out_valid (m2_valid),
        .y         (act)
    );

    rqu_fmul u_mul_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m2_valid),
        .a         (act),
        .b         (so_line_reg[SO_LAT-1]),
        .out_valid (m3_valid),
        .y         (y)
    );

    rqu_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m3_valid),
        .x         (y),
        .out_valid (out_valid),
        .q         (quantized)
    );

endmodule

// ----- rtl/rqu_checker.sv -----
// rqu_checker: port level assertions for the requantizer, bound to the top level
// depends on int32_to_int8_requantizer_unit
module rqu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic signed [7:0] quantized
);

    // a waiting transaction stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(quantized))
        else $error("output changed while stalled");

    // input backpressure only from a blocked result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quantized != -8'sd128))
        else $error("result outside -127..127");

endmodule

bind int32_to_int8_requantizer_unit rqu_checker u_rqu_checker (.*);
